// ===== sv/rti_pkg.sv =====
// Shared types and constants of the ray/triangle intersection core.
package rti_pkg;

  localparam int FIELD_W    = 21;
  localparam int REG_W      = 63;
  localparam int EPS_W      = 40;
  localparam int IDX_W      = 2;
  localparam int BARY_W     = 24;
  localparam int BARY_FRAC  = 20;
  localparam int DIST_W     = 31;
  localparam int QUOT_W     = 32;

  localparam logic [IDX_W-1:0] REG_VERTEX0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_EDGE1   = 2'd1;
  localparam logic [IDX_W-1:0] REG_EDGE2   = 2'd2;
  localparam logic [IDX_W-1:0] REG_EPSILON = 2'd3;

  localparam logic [EPS_W-1:0] EPS_RESET = 40'd11;

  localparam logic [QUOT_W-1:0] BARY_POS_LIMIT = 32'h007F_FFFF;
  localparam logic [QUOT_W-1:0] BARY_NEG_LIMIT = 32'h0080_0000;
  localparam logic [QUOT_W-1:0] DIST_LIMIT     = 32'h7FFF_FFFF;

  localparam logic [BARY_W-1:0] BARY_MAX = 24'h7F_FFFF;
  localparam logic [BARY_W-1:0] BARY_MIN = 24'h80_0000;
  localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    RSN_HIT      = 3'd0,
    RSN_PARALLEL = 3'd1,
    RSN_U_OUT    = 3'd2,
    RSN_V_OUT    = 3'd3,
    RSN_BEHIND   = 3'd4
  } reason_t;

  typedef struct packed {
    reason_t reason;
    logic    neg_u;
    logic    neg_v;
  } side_t;

endpackage

// ===== sv/ray_triangle_intersection_core.sv =====
// Moller-Trumbore ray/triangle intersection core, top level.
//
// Configuration: pulse cfg_write_enable with cfg_index and cfg_data to load
// vertex 0, edge 1, edge 2 (three packed signed coordinates each) or the
// determinant threshold. Write only while the pipeline is empty.
// Ray channel: each transaction carries origin and direction.
// Result channel: hit, miss_reason, distance, bary_u and bary_v, one
// transaction per ray, in order.
// Throughput is one ray per cycle while no result is stalled. Seven stages
// of multiply/add, a 32-stage restoring divider (one quotient bit per stage)
// and the output register make up the pipeline.
// When res_stall is high with a result waiting, the whole pipeline holds
// and ray_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values
// (zero triangle, threshold 11).
module ray_triangle_intersection_core import rti_pkg::*; #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_BITS   = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_enable,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]          cfg_data,
  input  logic                      ray_valid,
  output logic                      ray_stall,
  input  logic signed [FIELD_W-1:0] origin_x,
  input  logic signed [FIELD_W-1:0] origin_y,
  input  logic signed [FIELD_W-1:0] origin_z,
  input  logic signed [FIELD_W-1:0] direction_x,
  input  logic signed [FIELD_W-1:0] direction_y,
  input  logic signed [FIELD_W-1:0] direction_z,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      hit,
  output logic [2:0]                miss_reason,
  output logic [DIST_W-1:0]         distance,
  output logic signed [BARY_W-1:0]  bary_u,
  output logic signed [BARY_W-1:0]  bary_v
);

  localparam int W     = COORD_WIDTH;
  localparam int TW    = W + 1;
  localparam int PW    = 2 * W + 1;
  localparam int QW    = 2 * W + 2;
  localparam int LW    = W + 1;
  localparam int PPW   = 2 * W + 4;
  localparam int N     = 3 * W + 4;
  localparam int MAGW  = N - 1;
  localparam int NUM_W = MAGW + BARY_FRAC;
  localparam int CMPW  = MAGW + EPS_W;

  function automatic logic signed [N-1:0] join_pp(input logic signed [PPW-1:0] hi,
                                                  input logic signed [PPW-1:0] lo);
    return (N'(hi) <<< LW) + N'(lo);
  endfunction

  logic en;

  logic [REG_W-1:0] vertex0;
  logic [REG_W-1:0] edge1;
  logic [REG_W-1:0] edge2;
  logic [EPS_W-1:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex0 <= '0;
      edge1   <= '0;
      edge2   <= '0;
      epsilon <= EPS_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_VERTEX0: vertex0 <= cfg_data;
        REG_EDGE1:   edge1   <= cfg_data;
        REG_EDGE2:   edge2   <= cfg_data;
        REG_EPSILON: epsilon <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [W-1:0] v0 [3];
  logic signed [W-1:0] e1 [3];
  logic signed [W-1:0] e2 [3];
  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v0[k] = $signed(vertex0[k*W +: W]);
      e1[k] = $signed(edge1[k*W +: W]);
      e2[k] = $signed(edge2[k*W +: W]);
    end
    org[0] = $signed(origin_x[W-1:0]);
    org[1] = $signed(origin_y[W-1:0]);
    org[2] = $signed(origin_z[W-1:0]);
    dir[0] = $signed(direction_x[W-1:0]);
    dir[1] = $signed(direction_y[W-1:0]);
    dir[2] = $signed(direction_z[W-1:0]);
  end

  assign en        = !(res_valid && res_stall);
  assign ray_stall = !en;

  // stage 1
  logic                  v1;
  logic signed [TW-1:0]  t1 [3];
  logic signed [2*W-1:0] m1 [6];
  logic signed [W-1:0]   dir1 [3];

  // stage 2
  logic                  v2;
  logic signed [PW-1:0]  p2 [3];
  logic signed [PW-1:0]  qm2 [6];
  logic signed [TW-1:0]  t2 [3];
  logic signed [W-1:0]   dir2 [3];

  // stage 3
  logic                  v3;
  logic signed [QW-1:0]  q3 [3];
  logic signed [PPW-1:0] det_hi3 [3];
  logic signed [PPW-1:0] det_lo3 [3];
  logic signed [PPW-1:0] un_hi3 [3];
  logic signed [PPW-1:0] un_lo3 [3];
  logic signed [W-1:0]   dir3 [3];

  // stage 4
  logic                  v4;
  logic signed [N-1:0]   det4;
  logic signed [N-1:0]   un4;
  logic signed [PPW-1:0] vn_hi4 [3];
  logic signed [PPW-1:0] vn_lo4 [3];
  logic signed [PPW-1:0] tn_hi4 [3];
  logic signed [PPW-1:0] tn_lo4 [3];

  // stage 5
  logic                  v5;
  logic signed [N-1:0]   un5;
  logic signed [N-1:0]   vn5;
  logic signed [N-1:0]   tn5;
  logic                  dneg5;
  logic [MAGW-1:0]       dmag5;

  // stage 6
  logic                  v6;
  logic                  par6;
  logic signed [N-1:0]   un6;
  logic signed [N-1:0]   vn6;
  logic signed [N-1:0]   tn6;
  logic [MAGW-1:0]       dmag6;

  // stage 7
  logic                  v7;
  side_t                 side7;
  logic [MAGW-1:0]       dmag7;
  logic [2:0][NUM_W-1:0] num7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= ray_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t1[k]   <= TW'(org[k]) - TW'(v0[k]);
        dir1[k] <= dir[k];
      end
      m1[0] <= dir[1] * e2[2];
      m1[1] <= dir[2] * e2[1];
      m1[2] <= dir[2] * e2[0];
      m1[3] <= dir[0] * e2[2];
      m1[4] <= dir[0] * e2[1];
      m1[5] <= dir[1] * e2[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p2[k]   <= PW'(m1[2*k]) - PW'(m1[2*k+1]);
        t2[k]   <= t1[k];
        dir2[k] <= dir1[k];
      end
      qm2[0] <= t1[1] * e1[2];
      qm2[1] <= t1[2] * e1[1];
      qm2[2] <= t1[2] * e1[0];
      qm2[3] <= t1[0] * e1[2];
      qm2[4] <= t1[0] * e1[1];
      qm2[5] <= t1[1] * e1[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        q3[k]      <= QW'(qm2[2*k]) - QW'(qm2[2*k+1]);
        det_hi3[k] <= e1[k] * $signed(p2[k][PW-1:LW]);
        det_lo3[k] <= e1[k] * $signed({1'b0, p2[k][LW-1:0]});
        un_hi3[k]  <= t2[k] * $signed(p2[k][PW-1:LW]);
        un_lo3[k]  <= t2[k] * $signed({1'b0, p2[k][LW-1:0]});
        dir3[k]    <= dir2[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det4 <= join_pp(det_hi3[0], det_lo3[0]) + join_pp(det_hi3[1], det_lo3[1])
            + join_pp(det_hi3[2], det_lo3[2]);
      un4  <= join_pp(un_hi3[0], un_lo3[0]) + join_pp(un_hi3[1], un_lo3[1])
            + join_pp(un_hi3[2], un_lo3[2]);
      for (int k = 0; k < 3; k++) begin
        vn_hi4[k] <= dir3[k] * $signed(q3[k][QW-1:LW]);
        vn_lo4[k] <= dir3[k] * $signed({1'b0, q3[k][LW-1:0]});
        tn_hi4[k] <= e2[k] * $signed(q3[k][QW-1:LW]);
        tn_lo4[k] <= e2[k] * $signed({1'b0, q3[k][LW-1:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vn5   <= join_pp(vn_hi4[0], vn_lo4[0]) + join_pp(vn_hi4[1], vn_lo4[1])
             + join_pp(vn_hi4[2], vn_lo4[2]);
      tn5   <= join_pp(tn_hi4[0], tn_lo4[0]) + join_pp(tn_hi4[1], tn_lo4[1])
             + join_pp(tn_hi4[2], tn_lo4[2]);
      un5   <= un4;
      dneg5 <= det4[N-1];
      dmag5 <= det4[N-1] ? MAGW'(-det4) : MAGW'(det4);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par6  <= (dmag5 == '0) || (CMPW'(dmag5) < CMPW'(epsilon));
      un6   <= dneg5 ? -un5 : un5;
      vn6   <= dneg5 ? -vn5 : vn5;
      tn6   <= dneg5 ? -tn5 : tn5;
      dmag6 <= dmag5;
    end
  end

  reason_t               reason_next;
  logic [MAGW-1:0]       mag_u;
  logic [MAGW-1:0]       mag_v;
  logic [MAGW-1:0]       mag_t;
  logic signed [N:0]     uv_sum;

  always_comb begin
    uv_sum = (N+1)'(un6) + (N+1)'(vn6);
    mag_u  = un6[N-1] ? MAGW'(-un6) : MAGW'(un6);
    mag_v  = vn6[N-1] ? MAGW'(-vn6) : MAGW'(vn6);
    mag_t  = tn6[N-1] ? MAGW'(-tn6) : MAGW'(tn6);
    priority if (par6) begin
      reason_next = RSN_PARALLEL;
    end else if (un6[N-1] || (un6 > $signed({1'b0, dmag6}))) begin
      reason_next = RSN_U_OUT;
    end else if (vn6[N-1] || (uv_sum > $signed({2'b00, dmag6}))) begin
      reason_next = RSN_V_OUT;
    end else if (tn6[N-1]) begin
      reason_next = RSN_BEHIND;
    end else begin
      reason_next = RSN_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side7.reason <= reason_next;
      side7.neg_u  <= un6[N-1];
      side7.neg_v  <= vn6[N-1];
      dmag7        <= dmag6;
      num7[0]      <= NUM_W'(mag_u) << BARY_FRAC;
      num7[1]      <= NUM_W'(mag_v) << BARY_FRAC;
      num7[2]      <= NUM_W'(mag_t) << FRAC_BITS;
    end
  end

  logic                   div_valid;
  logic [2:0][QUOT_W-1:0] div_quot;
  logic [2:0]             div_ovf;
  side_t                  div_side;

  rti_divider #(
    .NUM_W (NUM_W),
    .DEN_W (MAGW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .den       (dmag7),
    .num       (num7),
    .side_in   (side7),
    .out_valid (div_valid),
    .quot      (div_quot),
    .ovf       (div_ovf),
    .side_out  (div_side)
  );

  logic [BARY_W-1:0] sat_u;
  logic [BARY_W-1:0] sat_v;
  logic [DIST_W-1:0] sat_t;

  always_comb begin
    if (div_side.neg_u) begin
      sat_u = (div_ovf[0] || div_quot[0] > BARY_NEG_LIMIT) ? BARY_MIN
            : BARY_W'(QUOT_W'(0) - div_quot[0]);
    end else begin
      sat_u = (div_ovf[0] || div_quot[0] > BARY_POS_LIMIT) ? BARY_MAX
            : div_quot[0][BARY_W-1:0];
    end
    if (div_side.neg_v) begin
      sat_v = (div_ovf[1] || div_quot[1] > BARY_NEG_LIMIT) ? BARY_MIN
            : BARY_W'(QUOT_W'(0) - div_quot[1]);
    end else begin
      sat_v = (div_ovf[1] || div_quot[1] > BARY_POS_LIMIT) ? BARY_MAX
            : div_quot[1][BARY_W-1:0];
    end
    sat_t = (div_ovf[2] || div_quot[2] > DIST_LIMIT) ? DIST_MAX
          : div_quot[2][DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit         <= (div_side.reason == RSN_HIT);
      miss_reason <= div_side.reason;
      distance    <= (div_side.reason == RSN_HIT) ? sat_t : DIST_MAX;
      bary_u      <= (div_side.reason == RSN_PARALLEL) ? '0 : $signed(sat_u);
      bary_v      <= (div_side.reason == RSN_PARALLEL || div_side.reason == RSN_U_OUT)
                     ? '0 : $signed(sat_v);
    end
  end

endmodule

// ===== sv/rti_divider.sv =====
// Pipelined restoring divider: three numerators over one shared divisor.
module rti_divider import rti_pkg::*; #(
  parameter int NUM_W = 86,
  parameter int DEN_W = 66
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [DEN_W-1:0]           den,
  input  logic [2:0][NUM_W-1:0]      num,
  input  side_t                      side_in,
  output logic                       out_valid,
  output logic [2:0][QUOT_W-1:0]     quot,
  output logic [2:0]                 ovf,
  output side_t                      side_out
);

  logic                    vld  [QUOT_W+1];
  logic [DEN_W-1:0]        dsr  [QUOT_W+1];
  logic [DEN_W-1:0]        rem  [QUOT_W+1][3];
  logic [QUOT_W-1:0]       low  [QUOT_W+1][3];
  logic [QUOT_W-1:0]       qacc [QUOT_W+1][3];
  logic                    ofl  [QUOT_W+1][3];
  side_t                   sd   [QUOT_W+1];

  always_comb begin
    vld[0] = in_valid;
    dsr[0] = den;
    sd[0]  = side_in;
    for (int j = 0; j < 3; j++) begin
      rem[0][j]  = DEN_W'(num[j] >> QUOT_W);
      low[0][j]  = num[j][QUOT_W-1:0];
      qacc[0][j] = '0;
      ofl[0][j]  = (num[j] >> QUOT_W) >= NUM_W'(den);
    end
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [DEN_W:0]      trial [3];
    logic                ge    [3];
    logic [DEN_W-1:0]    rem_next  [3];
    logic [QUOT_W-1:0]   qacc_next [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        trial[j] = {rem[k][j], low[k][j][QUOT_W-1-k]};
        ge[j] = trial[j] >= {1'b0, dsr[k]};
        rem_next[j] = ge[j] ? DEN_W'(trial[j] - {1'b0, dsr[k]}) : DEN_W'(trial[j]);
        qacc_next[j] = qacc[k][j];
        qacc_next[j][QUOT_W-1-k] = ge[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsr[k+1] <= dsr[k];
        sd[k+1]  <= sd[k];
        for (int j = 0; j < 3; j++) begin
          rem[k+1][j]  <= rem_next[j];
          low[k+1][j]  <= low[k][j];
          qacc[k+1][j] <= qacc_next[j];
          ofl[k+1][j]  <= ofl[k][j];
        end
      end
    end
  end

  always_comb begin
    out_valid = vld[QUOT_W];
    side_out  = sd[QUOT_W];
    for (int j = 0; j < 3; j++) begin
      quot[j] = qacc[QUOT_W][j];
      ovf[j]  = ofl[QUOT_W][j];
    end
  end

endmodule

// ===== bench/ray_triangle_intersection_core_test.sv =====
// Self-checking testbench for the ray/triangle intersection core: directed and random rays.
module ray_triangle_intersection_core_test import rti_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 1024;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic             hit;
    reason_t          reason;
    logic [DIST_W-1:0] dist_q;
    logic [BARY_W-1:0] u;
    logic [BARY_W-1:0] v;
  } hit_rec_t;

  typedef struct {
    int ox, oy, oz, dx, dy, dz;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_enable = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic ray_valid = 1'b0;
  logic ray_stall;
  logic signed [FIELD_W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [FIELD_W-1:0] direction_x = '0, direction_y = '0, direction_z = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic hit;
  logic [2:0] miss_reason;
  logic [DIST_W-1:0] distance;
  logic signed [BARY_W-1:0] bary_u, bary_v;

  ray_triangle_intersection_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the configuration
  logic [REG_W-1:0] tri_vertex0 = '0, tri_edge1 = '0, tri_edge2 = '0;
  logic [EPS_W-1:0] det_floor = EPS_RESET;
  int tv[3], ta[3], tb[3];

  hit_rec_t pending_hits[$];
  logic ray_taken = 1'b0;
  bit use_typed = 1'b0;
  hit_rec_t typed_hit;
  int mismatches = 0;
  int cycles = 0;
  bit hold_req = 1'b0;
  bit rx_calm = 1'b0;

  function automatic longint bary_quot(input logic signed [127:0] num, input logic [63:0] d,
                                       input int s, input longint lo, input longint hi);
    logic [127:0] mag, q;
    mag = num < 0 ? -num : num;
    q = (mag << s) / {64'd0, d};
    if (num >= 0) return q > 128'(hi) ? hi : longint'(q);
    return q > 128'(-lo) ? lo : -longint'(q);
  endfunction

  function automatic hit_rec_t trace_ray(input logic [FIELD_W-1:0] rx, ry, rz, sx, sy, sz);
    hit_rec_t r;
    longint ox, oy, oz, dx, dy, dz, vx, vy, vz, ax, ay, az, bx, by, bz;
    longint px, py, pz, det, tx, ty, tz, qx, qy, qz, u, v;
    logic [63:0] d;
    logic signed [127:0] un, vn, tn, dw;
    ox = longint'($signed(rx)); oy = longint'($signed(ry)); oz = longint'($signed(rz));
    dx = longint'($signed(sx)); dy = longint'($signed(sy)); dz = longint'($signed(sz));
    vx = longint'($signed(tri_vertex0[0+:21])); vy = longint'($signed(tri_vertex0[21+:21]));
    vz = longint'($signed(tri_vertex0[42+:21]));
    ax = longint'($signed(tri_edge1[0+:21])); ay = longint'($signed(tri_edge1[21+:21]));
    az = longint'($signed(tri_edge1[42+:21]));
    bx = longint'($signed(tri_edge2[0+:21])); by = longint'($signed(tri_edge2[21+:21]));
    bz = longint'($signed(tri_edge2[42+:21]));
    r.hit = 1'b0;
    r.dist_q = DIST_MAX;
    u = 0;
    v = 0;
    px = dy * bz - dz * by;
    py = dz * bx - dx * bz;
    pz = dx * by - dy * bx;
    det = ax * px + ay * py + az * pz;
    d = det < 0 ? 64'(-det) : 64'(det);
    if (d == 0 || d < {24'd0, det_floor}) begin
      r.reason = RSN_PARALLEL;
    end else begin
      tx = ox - vx; ty = oy - vy; tz = oz - vz;
      un = tx * px + ty * py + tz * pz;
      qx = ty * az - tz * ay;
      qy = tz * ax - tx * az;
      qz = tx * ay - ty * ax;
      vn = dx * qx + dy * qy + dz * qz;
      tn = bx * qx + by * qy + bz * qz;
      if (det < 0) begin
        un = -un; vn = -vn; tn = -tn;
      end
      dw = $signed({64'd0, d});
      u = bary_quot(un, d, BARY_FRAC, -64'sd8388608, 64'sd8388607);
      if (un < 0 || un > dw) begin
        r.reason = RSN_U_OUT;
      end else begin
        v = bary_quot(vn, d, BARY_FRAC, -64'sd8388608, 64'sd8388607);
        if (vn < 0 || un + vn > dw) begin
          r.reason = RSN_V_OUT;
        end else if (tn < 0) begin
          r.reason = RSN_BEHIND;
        end else begin
          r.reason = RSN_HIT;
          r.hit = 1'b1;
          r.dist_q = DIST_W'(bary_quot(tn, d, 10, 0, 64'sd2147483647));
        end
      end
    end
    r.u = u[BARY_W-1:0];
    r.v = v[BARY_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    hit_rec_t want;
    cycles <= cycles + 1;
    if (rst) begin
      ray_taken <= 1'b0;
    end else begin
      ray_taken <= ray_valid && !ray_stall;
      if (ray_valid && !ray_stall)
        pending_hits.push_back(use_typed ? typed_hit : trace_ray(origin_x, origin_y, origin_z,
                               direction_x, direction_y, direction_z));
      if (res_valid && !res_stall) begin
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction");
        end else begin
          want = pending_hits.pop_front();
          if (hit !== want.hit || miss_reason !== want.reason || distance !== want.dist_q ||
              bary_u !== want.u || bary_v !== want.v) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit %0b rsn %0d t %0d u %0d v %0d, got %0b %0d %0d %0d %0d",
                       want.hit, want.reason, want.dist_q, $signed(want.u), $signed(want.v),
                       hit, miss_reason, distance, bary_u, bary_v);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
        res_stall <= 1'b0;
      end else if (rx_calm) begin
        res_stall <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(5, 40)) @(negedge clk);
      end else begin
        res_stall <= $urandom_range(0, 99) < 25;
      end
    end
  end

  task automatic idle_gap(input bit calm);
    int n, r;
    r = $urandom_range(0, 99);
    n = calm ? 0 : (r < 50 ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(5, 30)));
    if (n > 0) begin
      ray_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_ray(input ray_row_t row, input bit calm);
    idle_gap(calm);
    ray_valid <= 1'b1;
    origin_x <= FIELD_W'(row.ox); origin_y <= FIELD_W'(row.oy); origin_z <= FIELD_W'(row.oz);
    direction_x <= FIELD_W'(row.dx); direction_y <= FIELD_W'(row.dy);
    direction_z <= FIELD_W'(row.dz);
    do @(negedge clk); while (!ray_taken);
  endtask

  task automatic drain();
    ray_valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic load_triangle(input logic [REG_W-1:0] v0, e1, e2, input logic [EPS_W-1:0] eps);
    cfg_write_enable <= 1'b1;
    cfg_index <= REG_VERTEX0; cfg_data <= v0;
    @(negedge clk);
    cfg_index <= REG_EDGE1; cfg_data <= e1;
    @(negedge clk);
    cfg_index <= REG_EDGE2; cfg_data <= e2;
    @(negedge clk);
    cfg_index <= REG_EPSILON; cfg_data <= {23'($urandom), eps};
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    tri_vertex0 = v0; tri_edge1 = e1; tri_edge2 = e2; det_floor = eps;
    for (int i = 0; i < 3; i++) begin
      tv[i] = int'($signed(v0[21*i+:21]));
      ta[i] = int'($signed(e1[21*i+:21]));
      tb[i] = int'($signed(e2[21*i+:21]));
    end
  endtask

  function automatic logic [REG_W-1:0] pack3(input int x, y, z);
    return {21'(z), 21'(y), 21'(x)};
  endfunction

  ray_row_t reset_rows[8] = '{
    '{1048575, 1048575, 1048575, 1048575, 1048575, 1048575},
    '{-1048576, -1048576, -1048576, -1048576, -1048576, -1048576},
    '{0, 0, 0, 0, 0, 0},
    '{1048575, -1048576, 0, -1048576, 1048575, 1},
    '{-1, -1, -1, -1, -1, -1},
    '{ONE, 0, -ONE, 0, 0, -ONE},
    '{349525, 699050, 1, 699050, 349525, 2},
    '{-699051, -349526, 5, -349526, -699051, 3}
  };

  ray_row_t unit_rows[14] = '{
    '{256, 256, ONE, 0, 0, -ONE},
    '{0, 0, ONE, 0, 0, -ONE},
    '{512, 512, ONE, 0, 0, -ONE},
    '{-256, 256, ONE, 0, 0, -ONE},
    '{2048, 0, ONE, 0, 0, -ONE},
    '{256, -256, ONE, 0, 0, -ONE},
    '{768, 768, ONE, 0, 0, -ONE},
    '{256, 256, -ONE, 0, 0, -ONE},
    '{256, 256, -ONE, 0, 0, ONE},
    '{256, 256, ONE, ONE, 0, 0},
    '{256, 256, 1048575, 0, 0, -1},
    '{1048575, 0, ONE, 0, 0, -ONE},
    '{-1048576, 0, ONE, 0, 0, -ONE},
    '{100, 300, 2 * ONE, 50, -20, -ONE}
  };

  task automatic random_ray(input int span, input bit noisy);
    ray_row_t row;
    int a, b, tgt[3], org[3], dir[3], k;
    if (noisy || $urandom_range(0, 99) < 20) begin
      row = '{int'($urandom), int'($urandom), int'($urandom),
              int'($urandom), int'($urandom), int'($urandom)};
    end else begin
      a = $urandom_range(0, 360) - 50;
      b = $urandom_range(0, 360) - 50;
      k = $urandom_range(0, 7);
      for (int i = 0; i < 3; i++) begin
        tgt[i] = tv[i] + (a * ta[i] + b * tb[i]) / 256;
        org[i] = tgt[i] + $urandom_range(0, 2 * span) - span;
        dir[i] = tgt[i] - org[i];
        if (k == 0) dir[i] = -dir[i];
        if (k == 1) dir[i] = dir[i] / 64;
      end
      row = '{org[0], org[1], org[2], dir[0], dir[1], dir[2]};
    end
    send_ray(row, rx_calm);
  endtask

  initial begin
    int span;
    logic [EPS_W-1:0] eps;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero triangle after reset: every ray is parallel
    typed_hit = '{1'b0, RSN_PARALLEL, DIST_MAX, '0, '0};
    use_typed = 1'b1;
    foreach (reset_rows[i]) send_ray(reset_rows[i], 1'b0);
    drain();
    use_typed = 1'b0;

    load_triangle(pack3(0, 0, 0), pack3(ONE, 0, 0), pack3(0, ONE, 0), EPS_RESET);
    foreach (unit_rows[i]) send_ray(unit_rows[i], 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      span = 1 << (6 + 2 * $urandom_range(0, 5));
      case ($urandom_range(0, 3))
        0: eps = '0;
        1: eps = EPS_RESET;
        2: eps = EPS_W'($urandom_range(0, 1 << 20));
        default: eps = EPS_W'({$urandom, $urandom}) >> $urandom_range(0, 39);
      endcase
      if (ph == 2) begin
        load_triangle('1, '1, '1, '1);
      end else if (ph == 5) begin
        load_triangle({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, '0);
      end else begin
        load_triangle(pack3($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                            $urandom_range(0, 2 * span) - span),
                      pack3($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                            $urandom_range(0, 2 * span) - span),
                      pack3($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                            $urandom_range(0, 2 * span) - span), eps);
      end
      rx_calm = (ph == 6);
      if (ph == 3) begin
        hold_req = 1'b1;
        rx_calm = 1'b1;
      end
      for (int n = 0; n < 92; n++) begin
        random_ray(span, ph == 2 || ph == 5);
        if (ph == 3 && n == 120 - 1) rx_calm = 1'b0;
      end
      rx_calm = 1'b0;
      drain();
    end

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
